### rtl/core/tmdc_pkg.sv
`timescale 1ns / 1ps

package tmdc_pkg;

    // Register file indexes
    localparam logic [2:0] CFG_EAST_LIMIT = 3'd0;
    localparam logic [2:0] CFG_WEST_LIMIT = 3'd1;
    localparam logic [2:0] CFG_START_BAND = 3'd2;
    localparam logic [2:0] CFG_STOP_BAND  = 3'd3;
    localparam logic [2:0] CFG_SUPPLY_ON  = 3'd4;
    localparam logic [2:0] CFG_SUPPLY_OFF = 3'd5;

    // Register reset values
    localparam logic signed [15:0] EAST_LIMIT_RST = 16'sd2500;
    localparam logic signed [15:0] WEST_LIMIT_RST = 16'sd4500;
    localparam logic [14:0]        START_BAND_RST = 15'd100;
    localparam logic [14:0]        STOP_BAND_RST  = 15'd20;
    localparam logic [11:0]        SUPPLY_ON_RST  = 12'd1241;
    localparam logic [11:0]        SUPPLY_OFF_RST = 12'd1016;

    // Key codes
    localparam logic [1:0] KEY_NONE  = 2'd0;
    localparam logic [1:0] KEY_RAISE = 2'd1;
    localparam logic [1:0] KEY_LOWER = 2'd2;

    // Motor drive codes
    localparam logic [1:0] DRIVE_OFF = 2'd0;
    localparam logic [1:0] DRIVE_FWD = 2'd1;
    localparam logic [1:0] DRIVE_BWD = 2'd2;

    typedef struct packed {
        logic signed [15:0] east_bound;
        logic signed [15:0] west_bound;
        logic [14:0]        start_band;
        logic [14:0]        stop_band;
        logic [11:0]        supply_on;
        logic [11:0]        supply_off;
    } t_cfg;

    typedef struct packed {
        logic signed [15:0] measured_pitch;
        logic [11:0]        supply_sample;
        logic               target_valid;
        logic signed [15:0] new_target;
        logic [1:0]         key_code;
    } t_item;

    typedef struct packed {
        logic [1:0] drive;
        logic       dead_time_request;
        logic       at_east_limit;
        logic       at_west_limit;
        logic       supply_good;
    } t_result;

endpackage

### rtl/core/tmdc_cfg_regs.sv
`timescale 1ns / 1ps

module tmdc_cfg_regs (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [2:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    output tmdc_pkg::t_cfg       o_cfg
);
    import tmdc_pkg::*;

    t_cfg r_cfg;

    // Load the addressed register; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.east_bound <= EAST_LIMIT_RST;
            r_cfg.west_bound <= WEST_LIMIT_RST;
            r_cfg.start_band <= START_BAND_RST;
            r_cfg.stop_band  <= STOP_BAND_RST;
            r_cfg.supply_on  <= SUPPLY_ON_RST;
            r_cfg.supply_off <= SUPPLY_OFF_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_EAST_LIMIT: r_cfg.east_bound <= signed'(i_cfg_data);
                CFG_WEST_LIMIT: r_cfg.west_bound <= signed'(i_cfg_data);
                CFG_START_BAND: r_cfg.start_band <= i_cfg_data[14:0];
                CFG_STOP_BAND:  r_cfg.stop_band  <= i_cfg_data[14:0];
                CFG_SUPPLY_ON:  r_cfg.supply_on  <= i_cfg_data[11:0];
                CFG_SUPPLY_OFF: r_cfg.supply_off <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/core/tmdc_ctrl.sv
`timescale 1ns / 1ps

module tmdc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  tmdc_pkg::t_item      i_item,
    input  tmdc_pkg::t_cfg       i_cfg,
    output tmdc_pkg::t_result    o_res
);
    import tmdc_pkg::*;

    logic signed [15:0] r_target;
    logic               r_supply_ok;
    logic               r_auto_raise;
    logic               r_auto_lower;
    logic               r_manual_raise;
    logic               r_manual_lower;
    logic               r_auto_active;
    logic               r_pause_raise;
    logic               r_pause_lower;

    logic signed [15:0] n_target;
    logic               n_supply_ok;
    logic               n_auto_raise;
    logic               n_auto_lower;
    logic               n_manual_raise;
    logic               n_manual_lower;
    logic               n_auto_active;
    logic               n_pause_raise;
    logic               n_pause_lower;

    logic               east;
    logic               west;
    logic               dead;
    logic signed [16:0] err;
    logic signed [16:0] band_pos;
    logic signed [16:0] band_neg;
    logic [16:0]        mag;
    logic [1:0]         drive;

    // End limits: west is checked only when east is not reached
    assign east = i_item.measured_pitch < i_cfg.east_bound;
    assign west = !east && (i_item.measured_pitch > i_cfg.west_bound);

    // Supply hysteresis, on test first
    always_comb begin
        n_supply_ok = r_supply_ok;
        if (i_item.supply_sample > i_cfg.supply_on) begin
            n_supply_ok = 1'b1;
        end else if (i_item.supply_sample < i_cfg.supply_off) begin
            n_supply_ok = 1'b0;
        end
    end

    // Error against the target, exact at 17 bits
    assign n_target = i_item.target_valid ? i_item.new_target : r_target;
    assign err      = 17'(i_item.measured_pitch) - 17'(n_target);
    assign mag      = err[16] ? 17'(-err) : 17'(err);
    assign band_pos = signed'({2'b00, i_cfg.start_band});
    assign band_neg = -band_pos;

    // Automatic decision, then key override, then drive choice
    always_comb begin
        dead           = 1'b0;
        n_auto_raise   = r_auto_raise;
        n_auto_lower   = r_auto_lower;
        n_manual_raise = r_manual_raise;
        n_manual_lower = r_manual_lower;
        n_auto_active  = r_auto_active;
        n_pause_raise  = r_pause_raise;
        n_pause_lower  = r_pause_lower;
        drive          = DRIVE_OFF;

        if (r_auto_active) begin
            if (err > band_pos) begin
                dead          = r_pause_raise;
                n_auto_raise  = 1'b1;
                n_auto_lower  = 1'b0;
                n_pause_raise = 1'b0;
                n_pause_lower = 1'b1;
            end else if (err < band_neg) begin
                dead          = r_pause_lower;
                n_auto_lower  = 1'b1;
                n_auto_raise  = 1'b0;
                n_pause_lower = 1'b0;
                n_pause_raise = 1'b1;
            end else if (mag < {2'b00, i_cfg.stop_band}) begin
                n_auto_raise = 1'b0;
                n_auto_lower = 1'b0;
            end
        end

        case (i_item.key_code)
            KEY_RAISE, KEY_LOWER: begin
                if (r_auto_active) begin
                    dead = 1'b1;
                end
                if (i_item.key_code == KEY_RAISE) begin
                    n_manual_raise = 1'b1;
                end else begin
                    n_manual_lower = 1'b1;
                end
                n_auto_raise  = 1'b0;
                n_auto_lower  = 1'b0;
                n_auto_active = 1'b0;
                n_pause_raise = 1'b1;
                n_pause_lower = 1'b1;
            end
            KEY_NONE: begin
                n_manual_raise = 1'b0;
                n_manual_lower = 1'b0;
                n_auto_active  = 1'b1;
            end
            default: ;
        endcase

        if (n_supply_ok) begin
            if ((n_auto_raise || n_manual_raise) && !east) begin
                drive = DRIVE_FWD;
            end else if ((n_auto_lower || n_manual_lower) && !west) begin
                drive = DRIVE_BWD;
            end
        end
    end

    // Commit state when the item moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target       <= '0;
            r_supply_ok    <= 1'b0;
            r_auto_raise   <= 1'b0;
            r_auto_lower   <= 1'b0;
            r_manual_raise <= 1'b0;
            r_manual_lower <= 1'b0;
            r_auto_active  <= 1'b0;
            r_pause_raise  <= 1'b1;
            r_pause_lower  <= 1'b1;
        end else if (i_adv) begin
            r_target       <= n_target;
            r_supply_ok    <= n_supply_ok;
            r_auto_raise   <= n_auto_raise;
            r_auto_lower   <= n_auto_lower;
            r_manual_raise <= n_manual_raise;
            r_manual_lower <= n_manual_lower;
            r_auto_active  <= n_auto_active;
            r_pause_raise  <= n_pause_raise;
            r_pause_lower  <= n_pause_lower;
        end
    end

    assign o_res.drive             = drive;
    assign o_res.dead_time_request = dead;
    assign o_res.at_east_limit     = east;
    assign o_res.at_west_limit     = west;
    assign o_res.supply_good       = n_supply_ok;

endmodule

### rtl/core/tilt_motor_deadband_controller.sv
`timescale 1ns / 1ps

// Tilt motor dead-band controller. One item per clock is accepted on the
// input channel while o_in_stall is low and yields exactly one result: the
// item is captured in an input register, the drive decision and controller
// state update are made by compare logic on it, and the result is held in an
// output register until transferred. A stalled output holds that register
// and, once the input register is full, the whole two-entry pipeline; a
// drained one lets a new item in every cycle. Configuration writes take
// effect on the next clock and are meant to be made while no item is in flight.
module tilt_motor_deadband_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // Input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic signed [15:0] i_measured_pitch,
    input  logic [11:0] i_supply_sample,
    input  logic        i_target_valid,
    input  logic signed [15:0] i_new_target,
    input  logic [1:0]  i_key_code,
    // Result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_drive,
    output logic        o_dead_time_request,
    output logic        o_at_east_limit,
    output logic        o_at_west_limit,
    output logic        o_supply_good
);
    import tmdc_pkg::*;

    t_cfg    cfg;
    t_item   r_s1_item;
    logic    r_s1_valid;
    t_result s2_res;
    t_result r_out_res;
    logic    r_out_valid;
    logic    s2_free;
    logic    adv;
    logic    in_xfer;

    tmdc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Pipeline flow control
    assign s2_free    = !r_out_valid || !i_out_stall;
    assign adv        = r_s1_valid && s2_free;
    assign o_in_stall = r_s1_valid && !s2_free;
    assign in_xfer    = i_in_valid && !o_in_stall;

    // Capture the input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_item.measured_pitch <= i_measured_pitch;
            r_s1_item.supply_sample  <= i_supply_sample;
            r_s1_item.target_valid   <= i_target_valid;
            r_s1_item.new_target     <= i_new_target;
            r_s1_item.key_code       <= i_key_code;
        end
    end

    tmdc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_item  (r_s1_item),
        .i_cfg   (cfg),
        .o_res   (s2_res)
    );

    // Hold the result until it is transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_res <= s2_res;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_drive             = r_out_res.drive;
    assign o_dead_time_request = r_out_res.dead_time_request;
    assign o_at_east_limit     = r_out_res.at_east_limit;
    assign o_at_west_limit     = r_out_res.at_west_limit;
    assign o_supply_good       = r_out_res.supply_good;

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import tmdc_pkg::*;

    localparam logic [1:0] KEY_UNUSED      = 2'd3;
    localparam logic [2:0] CFG_UNMAPPED_LO = 3'd6;
    localparam logic [2:0] CFG_UNMAPPED_HI = 3'd7;
    localparam int         QUIET_LIMIT     = 4000;
    localparam int         RANDOM_PER_SET  = 100;
    localparam int         PRINT_LIMIT     = 40;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_wr_en = 1'b0;
    logic [2:0]         i_cfg_index = '0;
    logic [15:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic signed [15:0] i_measured_pitch = '0;
    logic [11:0]        i_supply_sample = '0;
    logic               i_target_valid = 1'b0;
    logic signed [15:0] i_new_target = '0;
    logic [1:0]         i_key_code = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [1:0]         o_drive;
    logic               o_dead_time_request;
    logic               o_at_east_limit;
    logic               o_at_west_limit;
    logic               o_supply_good;

    tilt_motor_deadband_controller uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_measured_pitch    (i_measured_pitch),
        .i_supply_sample     (i_supply_sample),
        .i_target_valid      (i_target_valid),
        .i_new_target        (i_new_target),
        .i_key_code          (i_key_code),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_drive             (o_drive),
        .o_dead_time_request (o_dead_time_request),
        .o_at_east_limit     (o_at_east_limit),
        .o_at_west_limit     (o_at_west_limit),
        .o_supply_good       (o_supply_good)
    );

    always #1 i_clk = ~i_clk;

    // Ticks waiting to be sent and drive commands waiting to come back
    t_item   pending_ticks[$];
    t_result expected_commands[$];

    int error_count = 0;
    int command_count = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int quiet_cycles = 0;

    // Register copy and controller state of the prediction
    t_cfg               cfg_shadow = '{EAST_LIMIT_RST, WEST_LIMIT_RST, START_BAND_RST,
                                       STOP_BAND_RST, SUPPLY_ON_RST, SUPPLY_OFF_RST};
    logic signed [15:0] aim_angle = '0;
    bit                 supply_verdict = 1'b0;
    bit                 raise_auto = 1'b0;
    bit                 lower_auto = 1'b0;
    bit                 raise_held = 1'b0;
    bit                 lower_held = 1'b0;
    bit                 auto_on = 1'b0;
    bit                 raise_pause = 1'b1;
    bit                 lower_pause = 1'b1;

    // Stimulus generator state
    int         planned_aim = 0;
    int         key_run_left = 0;
    logic [1:0] key_run_code = KEY_NONE;

    // Compute the drive command for one tick and advance the controller state
    function automatic t_result controller_step(t_item tick);
        int      pitch_v, east_v, west_v, aim_v, err, mag, start_v, stop_v;
        bit      east, west, dead;
        t_result cmd;
        pitch_v = $signed(tick.measured_pitch);
        east_v  = $signed(cfg_shadow.east_bound);
        west_v  = $signed(cfg_shadow.west_bound);
        start_v = cfg_shadow.start_band;
        stop_v  = cfg_shadow.stop_band;
        east = 1'b0;
        west = 1'b0;
        dead = 1'b0;

        if (pitch_v < east_v) begin
            east = 1'b1;
        end else if (pitch_v > west_v) begin
            west = 1'b1;
        end

        if (tick.supply_sample > cfg_shadow.supply_on) begin
            supply_verdict = 1'b1;
        end else if (tick.supply_sample < cfg_shadow.supply_off) begin
            supply_verdict = 1'b0;
        end

        if (tick.target_valid) begin
            aim_angle = tick.new_target;
        end
        aim_v = $signed(aim_angle);

        // Automatic decision uses the mode as it stood before this key
        err = pitch_v - aim_v;
        mag = (err < 0) ? -err : err;
        if (auto_on) begin
            if (err > start_v) begin
                if (raise_pause) dead = 1'b1;
                raise_auto  = 1'b1;
                lower_auto  = 1'b0;
                raise_pause = 1'b0;
                lower_pause = 1'b1;
            end else if (err < -start_v) begin
                if (lower_pause) dead = 1'b1;
                lower_auto  = 1'b1;
                raise_auto  = 1'b0;
                lower_pause = 1'b0;
                raise_pause = 1'b1;
            end else if (mag < stop_v) begin
                raise_auto = 1'b0;
                lower_auto = 1'b0;
            end
        end

        // Keys override automatic mode; the unused code changes nothing
        if (tick.key_code == KEY_RAISE || tick.key_code == KEY_LOWER) begin
            if (auto_on) dead = 1'b1;
            if (tick.key_code == KEY_RAISE) raise_held = 1'b1;
            else lower_held = 1'b1;
            raise_auto  = 1'b0;
            lower_auto  = 1'b0;
            auto_on     = 1'b0;
            raise_pause = 1'b1;
            lower_pause = 1'b1;
        end else if (tick.key_code == KEY_NONE) begin
            raise_held = 1'b0;
            lower_held = 1'b0;
            auto_on    = 1'b1;
        end

        cmd.drive = DRIVE_OFF;
        if (supply_verdict) begin
            if ((raise_auto || raise_held) && !east) begin
                cmd.drive = DRIVE_FWD;
            end else if ((lower_auto || lower_held) && !west) begin
                cmd.drive = DRIVE_BWD;
            end
        end
        cmd.dead_time_request = dead;
        cmd.at_east_limit     = east;
        cmd.at_west_limit     = west;
        cmd.supply_good       = supply_verdict;
        return cmd;
    endfunction

    function automatic int clamp(int v, int lo, int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic report_mismatch(string what);
        if (error_count < PRINT_LIMIT) begin
            $display("%0t: mismatch: %s", $realtime, what);
        end
        error_count++;
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want) begin
            report_mismatch($sformatf("command %0d %s got %0d want %0d",
                                      command_count, name, got, want));
        end
    endtask

    task automatic push_tick(int pitch, int sample, bit tv, int target, logic [1:0] key);
        pending_ticks.push_back('{measured_pitch: 16'(pitch), supply_sample: 12'(sample),
                                  target_valid: tv, new_target: 16'(target), key_code: key});
        if (tv) planned_aim = target;
    endtask

    // Mostly released keys with short held runs, pitch near the band edges,
    // supply mostly good with samples around both thresholds
    task automatic push_random_tick();
        int         pitch, sample, target, band, pick;
        bit         tv;
        logic [1:0] key;
        if (key_run_left > 0) begin
            key = key_run_code;
            key_run_left--;
        end else if ($urandom_range(99) < 8) begin
            pick = $urandom_range(9);
            key_run_code = (pick < 5) ? KEY_RAISE : (pick < 9) ? KEY_LOWER : KEY_UNUSED;
            key_run_left = $urandom_range(3);
            key = key_run_code;
        end else begin
            key = KEY_NONE;
        end

        tv = ($urandom_range(99) < 10);
        target = int'($urandom_range(35999)) - 18000;

        if ($urandom_range(9) < 2) begin
            pitch = int'($urandom_range(35999)) - 18000;
        end else begin
            case ($urandom_range(3))
                0: band = cfg_shadow.start_band;
                1: band = cfg_shadow.stop_band;
                2: band = $urandom_range(2 * cfg_shadow.start_band + 50);
                default: band = 0;
            endcase
            band = band + int'($urandom_range(6)) - 3;
            if ($urandom_range(1)) band = -band;
            pitch = (tv ? target : planned_aim) + band;
        end
        pitch = clamp(pitch, -18000, 17999);

        pick = $urandom_range(9);
        if (pick < 2) begin
            sample = $urandom_range(4095);
        end else if (pick < 4) begin
            sample = int'(cfg_shadow.supply_on) + int'($urandom_range(6)) - 3;
        end else if (pick < 6) begin
            sample = int'(cfg_shadow.supply_off) + int'($urandom_range(6)) - 3;
        end else begin
            sample = $urandom_range(4095, cfg_shadow.supply_on);
        end
        sample = clamp(sample, 0, 4095);

        push_tick(pitch, sample, tv, target, key);
    endtask

    task automatic write_register(logic [2:0] idx, logic [15:0] data);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_EAST_LIMIT: cfg_shadow.east_bound = data;
            CFG_WEST_LIMIT: cfg_shadow.west_bound = data;
            CFG_START_BAND: cfg_shadow.start_band = data[14:0];
            CFG_STOP_BAND:  cfg_shadow.stop_band  = data[14:0];
            CFG_SUPPLY_ON:  cfg_shadow.supply_on  = data[11:0];
            CFG_SUPPLY_OFF: cfg_shadow.supply_off = data[11:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(int east, int west, int start, int stop, int on_lvl,
                                 int off_lvl);
        write_register(CFG_EAST_LIMIT, 16'(east));
        write_register(CFG_WEST_LIMIT, 16'(west));
        write_register(CFG_START_BAND, 16'(start));
        write_register(CFG_STOP_BAND, 16'(stop));
        write_register(CFG_SUPPLY_ON, 16'(on_lvl));
        write_register(CFG_SUPPLY_OFF, 16'(off_lvl));
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_for_drain();
        while (pending_ticks.size() != 0 || expected_commands.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (3) @(posedge i_clk);
    endtask

    // Driver: present the oldest pending tick, hold it while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_commands.push_back(controller_step(pending_ticks.pop_front()));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_ticks.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    i_in_valid <= 1'b1;
                    {i_measured_pitch, i_supply_sample, i_target_valid, i_new_target,
                     i_key_code} <= pending_ticks[0];
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each transferred command with the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_commands.size() == 0) begin
                report_mismatch("drive command with nothing expected");
            end else begin
                want = expected_commands.pop_front();
                check_field("drive", o_drive, want.drive);
                check_field("dead_time_request", o_dead_time_request,
                            want.dead_time_request);
                check_field("at_east_limit", o_at_east_limit, want.at_east_limit);
                check_field("at_west_limit", o_at_west_limit, want.at_west_limit);
                check_field("supply_good", o_supply_good, want.supply_good);
            end
            command_count++;
        end
        i_out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[tilt_motor_deadband_controller] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int east, west, start;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed ticks under the reset settings
        push_tick(-18000, 4095, 1'b1, 17999, KEY_NONE);
        push_tick(17999, 4095, 1'b0, 0, KEY_NONE);
        push_tick(3000, 2000, 1'b1, 0, KEY_NONE);
        push_tick(3050, 2000, 1'b0, 0, KEY_NONE);
        // error inside the hysteresis band, then exactly on the start band
        push_tick(3500, 2000, 1'b1, 3560, KEY_NONE);
        push_tick(3500, 2000, 1'b1, 3600, KEY_NONE);
        // reversal, then stop inside the stop band
        push_tick(3499, 2000, 1'b0, 0, KEY_NONE);
        push_tick(3595, 2000, 1'b0, 0, KEY_NONE);
        // supply thresholds: on the off level, below it, on the on level, above it
        push_tick(3800, 1016, 1'b0, 0, KEY_NONE);
        push_tick(3800, 1015, 1'b0, 0, KEY_NONE);
        push_tick(3800, 1241, 1'b0, 0, KEY_NONE);
        push_tick(3800, 1242, 1'b0, 0, KEY_NONE);
        // keys: raise over auto, both held, unused code, release
        push_tick(3800, 2000, 1'b0, 0, KEY_RAISE);
        push_tick(3800, 2000, 1'b0, 0, KEY_LOWER);
        push_tick(3800, 2000, 1'b0, 0, KEY_UNUSED);
        push_tick(3800, 2000, 1'b0, 0, KEY_NONE);
        // end limits against manual drive
        push_tick(4600, 2000, 1'b0, 0, KEY_LOWER);
        push_tick(2000, 2000, 1'b0, 0, KEY_LOWER);
        push_tick(2000, 2000, 1'b0, 0, KEY_RAISE);
        push_tick(3000, 2000, 1'b0, 0, KEY_UNUSED);
        push_tick(3600, 2000, 1'b0, 0, KEY_NONE);
        // widest errors both ways
        push_tick(-18000, 4095, 1'b0, 0, KEY_NONE);
        push_tick(17999, 4095, 1'b0, 0, KEY_NONE);
        push_tick(17999, 0, 1'b1, -18000, KEY_NONE);
        wait_for_drain();

        for (int set = 1; set <= 6; set++) begin
            case (set)
                2: load_settings(-18000, 18000, 0, 0, 0, 0);
                3: load_settings(18000, -18000, 18000, 18000, 4095, 4095);
                4: begin
                    // unmapped indexes are ignored; bands and levels inverted
                    write_register(CFG_UNMAPPED_LO, 16'($urandom));
                    write_register(CFG_UNMAPPED_HI, 16'($urandom));
                    load_settings(-1000, 3000, 50, 300, 1000, 1500);
                end
                default: begin
                    east  = int'($urandom_range(6000)) - 3000;
                    west  = east + int'($urandom_range(4000));
                    start = $urandom_range(400, 20);
                    load_settings(east, west, start, $urandom_range(start),
                                  $urandom_range(1400, 1100), $urandom_range(1100, 800));
                end
            endcase
            case (set)
                2: begin sender_idle_pct = 79; receiver_stall_pct = 0;  end
                3: begin sender_idle_pct = 0;  receiver_stall_pct = 79; end
                4, 6: begin sender_idle_pct = 32; receiver_stall_pct = 32; end
                default: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
            endcase
            repeat (RANDOM_PER_SET) push_random_tick();
            wait_for_drain();
        end

        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[tilt_motor_deadband_controller] OK");
        end else begin
            $display("[tilt_motor_deadband_controller] ERROR");
        end
        $finish;
    end

endmodule
